@@ hw/rtl/sepm_pkg.sv @@
package sepm_pkg;

  localparam int unsigned MAX_PATTERN_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned PAT_REG_W         = 64;
  localparam int unsigned LEN_W             = 5;
  localparam int unsigned CHAR_IDX_W        = 4;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned START_W           = 16;
  localparam int unsigned IN_TDATA_W        = 8;
  localparam int unsigned OUT_TDATA_W       = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic       shift;
    logic       clear;
    logic       active;
    logic [7:0] expect_char;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/sepm_cell.sv @@
module sepm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sepm_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          din_i,
  output logic [7:0]          q_o,
  output logic                hit_o
);
  import sepm_pkg::*;

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = 8'd0;
    end else if (ctrl_i.shift) begin
      byte_d = din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign q_o   = byte_q;
  assign hit_o = !ctrl_i.active || (din_i == ctrl_i.expect_char);

endmodule

@@ hw/rtl/streaming_exact_pattern_matcher_top.sv @@
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] text_byte, tlast last_byte
// m_axis    out  m_axis_tvalid/tready       tdata: match_here, found, first_match_start
//                                           tlast text_done
// cfg       in   cfg_we_i                   cfg_idx_i register, cfg_data_i value
//
// One request per cycle while s_axis_tready is high; the result appears the cycle after acceptance.
// The compare runs across a row of byte cells in the cycle a byte enters.
// Reset clears the window, position, match latch, output valid and pattern; length resets to 1.
// A stalled result holds in the output register; s_axis_tready stays high
// while that register is empty or being drained.
module streaming_exact_pattern_matcher_top #(
  parameter int unsigned MAX_PATTERN   = sepm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = sepm_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sepm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] text_byte
  input  logic                               s_axis_tlast,   // last_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sepm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [0] match_here,
                                                             // [1] found,
                                                             // [17:2] first_match_start,
                                                             // [23:18] zero
  output logic                               m_axis_tlast,   // text_done
  input  logic                               cfg_we_i,
  input  logic [sepm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sepm_pkg::PAT_REG_W-1:0]     cfg_data_i
);
  import sepm_pkg::*;

  logic [PAT_REG_W-1:0]     pat_low_q;
  logic [PAT_REG_W-1:0]     pat_high_q;
  logic [LEN_W-1:0]         pat_len_q;
  logic [2*PAT_REG_W-1:0]   pat_all;
  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         len_m1;

  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] pos_d;
  logic                     found_q;
  logic                     found_d;
  logic [POSITION_BITS-1:0] first_q;
  logic [POSITION_BITS-1:0] first_d;

  logic                     accept;
  logic                     pos_ok;
  logic                     match;
  logic [MAX_PATTERN-1:0]   hit;
  logic [7:0]               win [MAX_PATTERN];
  cell_ctrl_t               ctrl [MAX_PATTERN];

  logic                     out_valid_q;
  logic                     out_match_q;
  logic                     out_found_q;
  logic [START_W-1:0]       out_start_q;
  logic                     out_last_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        REG_PAT_HIGH: pat_high_q <= cfg_data_i;
        REG_PAT_LEN:  pat_len_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_high_q, pat_low_q};

  always_comb begin
    len = pat_len_q;
    if (pat_len_q == '0) begin
      len = LEN_W'(1);
    end else if (pat_len_q > LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end
  end

  assign len_m1 = len - LEN_W'(1);
  assign accept = s_axis_tvalid && s_axis_tready;

  // window cells
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_W-1:0] char_idx;
    logic [7:0]       din;

    assign char_idx = len_m1 - LEN_W'(k);

    if (k == 0) begin : g_head
      assign din = s_axis_tdata[7:0];
    end else begin : g_link
      assign din = win[k-1];
    end

    assign ctrl[k].shift       = accept;
    assign ctrl[k].clear       = accept && s_axis_tlast;
    assign ctrl[k].active      = LEN_W'(k) < len;
    assign ctrl[k].expect_char = pat_all[char_idx[CHAR_IDX_W-1:0]*8 +: 8];

    sepm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[k]),
      .din_i  (din),
      .q_o    (win[k]),
      .hit_o  (hit[k])
    );
  end

  assign pos_ok = pos_q >= POSITION_BITS'(len_m1);
  assign match  = pos_ok && (&hit);

  always_comb begin
    found_d = found_q | match;
    first_d = found_q ? first_q : (pos_q - POSITION_BITS'(len_m1));
    pos_d   = (pos_q == '1) ? pos_q : pos_q + POSITION_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      found_q <= 1'b0;
      first_q <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        pos_q   <= '0;
        found_q <= 1'b0;
        first_q <= '0;
      end else begin
        pos_q   <= pos_d;
        found_q <= found_d;
        first_q <= first_d;
      end
    end
  end

  // output register
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_match_q <= match;
      out_found_q <= found_d;
      out_start_q <= found_d ? START_W'(first_d) : '0;
      out_last_q  <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_start_q, out_found_q, out_match_q};
  assign m_axis_tlast  = out_last_q;

endmodule

@@ hw/rtl/sepm_checker.sv @@
module sepm_assert (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sepm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import sepm_pkg::*;

  a_match_sets_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
    else $error("match reported without found");

  a_start_zero_unfound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[17:2] == '0))
    else $error("start index nonzero while not found");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind streaming_exact_pattern_matcher_top sepm_assert u_sepm_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
